@@ rtl/ial_pkg.sv @@
// Shared types and constants for the indexed array list.
package ial_pkg;

    localparam int unsigned IDX_W = 8;
    localparam int unsigned CNT_W = 9;
    localparam int unsigned VAL_W = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_PRIOR  = 3'd4,
        OP_NEXT   = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] result_value;
        logic [IDX_W-1:0]        position;
        logic [CNT_W-1:0]        count;
    } t_rsp;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             eval;
        logic             wr_ins;
        logic             wr_del;
        logic             rd_idx;
        logic             rd_prior;
        logic             rd_next;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ rtl/ial_cell.sv @@
// One list slot: holds a word, shifts with its neighbors, compares and offers its word.
module ial_cell #(
    parameter int unsigned POS = 0
) (
    input  logic                        i_clk,
    input  ial_pkg::t_cell_ctl          i_ctl,
    input  logic [ial_pkg::VAL_W-1:0]   i_left,
    input  logic [ial_pkg::VAL_W-1:0]   i_right,
    input  logic                        i_first_left,
    input  logic                        i_first_right,
    output logic [ial_pkg::VAL_W-1:0]   o_data,
    output logic                        o_match,
    output logic [ial_pkg::VAL_W-1:0]   o_rd
);
    import ial_pkg::*;

    localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    logic             r_match;
    logic             live;
    logic             pick;

    assign live = POS_C < i_ctl.count;

    always_comb begin
        n_data = r_data;
        if (i_ctl.wr_ins) begin
            if (POS_C == i_ctl.idx) begin
                n_data = i_ctl.value;
            end else if (POS_C > i_ctl.idx && POS_C <= i_ctl.count) begin
                n_data = i_left;
            end
        end else if (i_ctl.wr_del) begin
            if (POS_C >= i_ctl.idx && (POS_C + 1'b1) < i_ctl.count) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.eval) begin
            r_match <= live && (r_data == i_ctl.value);
        end
    end

    // word offered for get/delete, or as neighbor of the first match
    assign pick = (i_ctl.rd_idx && live && POS_C == i_ctl.idx)
               || (i_ctl.rd_prior && i_first_right)
               || (i_ctl.rd_next && i_first_left && live);

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_rd    = pick ? r_data : '0;

endmodule

@@ rtl/indexed_array_list.sv @@
// Indexed array list: controller and chain of DEPTH list cells.
// Result: the request is registered, the cells compare (S_EVAL), select/shift (S_COMMIT),
// and the response and strobe are registered (output); busy covers compare and select/shift.
// The next item is accepted in the cycle its predecessor's result is strobed.
// Reset (synchronous, active low) empties the list and idles the controller; cell
// words are not cleared. The receiver cannot stall: each result shows for one cycle.
module indexed_array_list #(
    parameter int unsigned DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ial_pkg::t_req  i_req,
    output logic           busy,
    output logic           o_strobe,
    output ial_pkg::t_rsp  o_rsp
);
    import ial_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count, n_count;
    t_rsp             r_rsp, n_rsp;
    logic             r_strobe;

    t_cell_ctl        ctl;
    logic [VAL_W-1:0] data  [DEPTH];
    logic [VAL_W-1:0] rd    [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] first;
    logic             any;
    logic [IDX_W-1:0] pos_m;
    logic [VAL_W-1:0] rd_or;
    logic [CNT_W-1:0] idx_w;
    logic [CNT_W-1:0] idx_cl;
    logic             commit;
    logic             ins_ok, del_ok, get_ok, prior_ok, next_ok;

    assign busy   = r_state != S_IDLE;
    assign commit = r_state == S_COMMIT;

    always_comb begin
        unique case (r_state)
            S_IDLE:   n_state = start ? S_EVAL : S_IDLE;
            S_EVAL:   n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign idx_w  = CNT_W'(r_req.index);
    assign idx_cl = (idx_w > r_count) ? r_count : idx_w;

    // first match as a one-hot, then its position
    assign first = match & (~match + 1'b1);
    assign any   = |match;

    always_comb begin
        pos_m = '0;
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (first[k]) begin
                pos_m = pos_m | IDX_W'(k);
            end
            rd_or = rd_or | rd[k];
        end
    end

    assign ins_ok   = r_req.opcode == OP_INSERT && r_count < DEPTH_C;
    assign del_ok   = r_req.opcode == OP_DELETE && idx_w < r_count;
    assign get_ok   = idx_w < r_count;
    assign prior_ok = any && pos_m != '0;
    assign next_ok  = any && (CNT_W'(pos_m) + 1'b1) < r_count;

    always_comb begin
        ctl.eval     = r_state == S_EVAL;
        ctl.wr_ins   = commit && ins_ok;
        ctl.wr_del   = commit && del_ok;
        ctl.rd_idx   = commit && (r_req.opcode == OP_GET || r_req.opcode == OP_DELETE);
        ctl.rd_prior = commit && r_req.opcode == OP_PRIOR;
        ctl.rd_next  = commit && r_req.opcode == OP_NEXT;
        ctl.idx      = idx_cl;
        ctl.count    = r_count;
        ctl.value    = r_req.value;
    end

    always_comb begin
        n_count             = r_count;
        n_rsp.ok            = 1'b0;
        n_rsp.result_value  = '0;
        n_rsp.position      = '0;
        unique case (r_req.opcode)
            OP_INSERT: begin
                n_rsp.ok = ins_ok;
                if (ins_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                n_rsp.ok           = del_ok;
                n_rsp.result_value = rd_or;
                if (del_ok) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_GET: begin
                n_rsp.ok           = get_ok;
                n_rsp.result_value = rd_or;
            end
            OP_LOCATE: begin
                n_rsp.ok       = any;
                n_rsp.position = pos_m;
            end
            OP_PRIOR: begin
                n_rsp.ok           = prior_ok;
                n_rsp.result_value = rd_or;
            end
            OP_NEXT: begin
                n_rsp.ok           = next_ok;
                n_rsp.result_value = rd_or;
            end
            OP_CLEAR: begin
                n_rsp.ok = 1'b1;
                n_count  = '0;
            end
            default: begin
            end
        endcase
        n_rsp.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= commit;
            if (commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left, right;
        logic             f_left, f_right;

        if (g == 0) begin : g_lo
            assign left   = '0;
            assign f_left = 1'b0;
        end else begin : g_lo
            assign left   = data[g-1];
            assign f_left = first[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign right   = '0;
            assign f_right = 1'b0;
        end else begin : g_hi
            assign right   = data[g+1];
            assign f_right = first[g+1];
        end

        ial_cell #(
            .POS (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_left        (left),
            .i_right       (right),
            .i_first_left  (f_left),
            .i_first_right (f_right),
            .o_data        (data[g]),
            .o_match       (match[g]),
            .o_rd          (rd[g])
        );
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
